### hdl/vp6fhd_pkg.sv
// Shared types and constants for the VP6 frame header dimension unit.
`timescale 1ns / 1ps

package vp6fhd_pkg;

    // Result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_SHORT     = 2'd1;
    localparam logic [1:0] ST_NO_REF    = 2'd2;
    localparam logic [1:0] ST_BAD_DIM   = 2'd3;

    localparam int DIM_W = 12;

    // Byte positions inside the header
    localparam logic [3:0] POS_FIRST    = 4'd0;
    localparam logic [3:0] POS_VERSION  = 4'd1;
    localparam logic [3:0] POS_DIMS     = 4'd2;
    localparam logic [3:0] POS_HGT      = 4'd4;
    localparam logic [3:0] POS_HGT_OFS  = 4'd6;
    localparam logic [3:0] POS_MAX      = 4'd15;

    // Per-frame header state
    typedef struct packed {
        logic       inter;
        logic       marker;
        logic       offset;
        logic [7:0] held_adjust;
        logic [7:0] height_code;
        logic [7:0] width_code;
        logic       complete;
    } frame_state_t;

    // Reference dimensions from the last good frame
    typedef struct packed {
        logic             valid;
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
    } ref_dims_t;

    // One result item
    typedef struct packed {
        logic             key_frame;
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        logic [1:0]       status;
    } result_t;

endpackage

### hdl/vp6fhd_result.sv
// Result evaluation for the last byte of a frame: dimensions and status.
`timescale 1ns / 1ps

module vp6fhd_result
(
    input  vp6fhd_pkg::frame_state_t frame,
    input  logic                     first_byte,
    input  vp6fhd_pkg::ref_dims_t    ref_dims,
    output vp6fhd_pkg::result_t      result
);

    logic [vp6fhd_pkg::DIM_W-1:0] full_w;
    logic [vp6fhd_pkg::DIM_W-1:0] full_h;
    logic [vp6fhd_pkg::DIM_W-1:0] nib_w;
    logic [vp6fhd_pkg::DIM_W-1:0] nib_h;
    logic [vp6fhd_pkg::DIM_W-1:0] dim_w;
    logic [vp6fhd_pkg::DIM_W-1:0] dim_h;
    logic                         bad_w;
    logic                         bad_h;

    // Code times 16 minus the adjustment nibble
    assign full_w = {frame.width_code, 4'b0000};
    assign full_h = {frame.height_code, 4'b0000};
    assign nib_w  = {8'd0, frame.held_adjust[7:4]};
    assign nib_h  = {8'd0, frame.held_adjust[3:0]};
    assign dim_w  = full_w - nib_w;
    assign dim_h  = full_h - nib_h;
    assign bad_w  = (frame.width_code == 8'd0) || (nib_w > full_w) || (dim_w == '0);
    assign bad_h  = (frame.height_code == 8'd0) || (nib_h > full_h) || (dim_h == '0);

    always_comb
    begin
        result.key_frame = ~frame.inter;
        result.width     = '0;
        result.height    = '0;
        result.status    = vp6fhd_pkg::ST_OK;
        if (first_byte)
        begin
            result.status = vp6fhd_pkg::ST_SHORT;
        end
        else if (frame.inter)
        begin
            if (ref_dims.valid)
            begin
                result.width  = ref_dims.width;
                result.height = ref_dims.height;
            end
            else
            begin
                result.status = vp6fhd_pkg::ST_NO_REF;
            end
        end
        else if (!frame.complete)
        begin
            result.status = vp6fhd_pkg::ST_SHORT;
        end
        else if (bad_w || bad_h)
        begin
            result.status = vp6fhd_pkg::ST_BAD_DIM;
        end
        else
        begin
            result.width  = dim_w;
            result.height = dim_h;
        end
    end

endmodule

### hdl/vp6_frame_header_dims_unit.sv
// Top level of the VP6 frame header dimension unit.
`timescale 1ns / 1ps

// Streams one VP6 frame payload a byte per request and reports, on the last
// byte, the key-frame flag, the frame width and height and a status code.
// A new byte is accepted every cycle: the per-byte work is a position
// counter step and a capture of header fields, and the result for a frame
// is formed in the same cycle as its last byte and held in an output
// register. Input stalls only while that output register holds a result
// that the sink has not taken. A key frame that completes with good
// dimensions updates the stored reference; inter frames report the
// reference, or status 2 if none exists yet. Errors report zero dimensions
// and leave the reference untouched.

module vp6_frame_header_dims_unit
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [7:0] data_byte, [15:8] adjustment
    input  logic        s_axis_tlast,   // last_byte

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [11:0] width, [23:12] height,
                                        // [25:24] status, [31:26] zero
    output logic        m_axis_tuser    // key_frame
);

    logic [7:0]               data_byte;
    logic [7:0]               adjustment;
    logic                     accept;

    logic [3:0]               pos_reg;
    logic [3:0]               pos_next;
    vp6fhd_pkg::frame_state_t frame_reg;
    vp6fhd_pkg::frame_state_t frame_next;
    vp6fhd_pkg::frame_state_t frame_upd;
    vp6fhd_pkg::ref_dims_t    ref_reg;
    vp6fhd_pkg::ref_dims_t    ref_next;
    vp6fhd_pkg::result_t      result;
    vp6fhd_pkg::result_t      out_reg;
    vp6fhd_pkg::result_t      out_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic [3:0]               hgt_pos;

    assign data_byte  = s_axis_tdata[7:0];
    assign adjustment = s_axis_tdata[15:8];

    // Take a byte unless a finished result is still waiting
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Capture header fields of the current byte
    always_comb
    begin
        frame_upd = frame_reg;
        if (pos_reg == vp6fhd_pkg::POS_FIRST)
        begin
            frame_upd.inter       = data_byte[7];
            frame_upd.marker      = data_byte[0];
            frame_upd.held_adjust = adjustment;
        end
        else if (pos_reg == vp6fhd_pkg::POS_VERSION)
        begin
            frame_upd.offset = frame_reg.marker && (data_byte[2:1] == 2'b00);
        end
        hgt_pos = frame_upd.offset ? vp6fhd_pkg::POS_HGT_OFS : vp6fhd_pkg::POS_HGT;
        if (pos_reg >= vp6fhd_pkg::POS_DIMS && pos_reg == hgt_pos)
        begin
            frame_upd.height_code = data_byte;
        end
        if (pos_reg >= vp6fhd_pkg::POS_DIMS && pos_reg == hgt_pos + 4'd1)
        begin
            frame_upd.width_code = data_byte;
            frame_upd.complete   = 1'b1;
        end
    end

    vp6fhd_result u_result
    (
        .frame      (frame_upd),
        .first_byte (pos_reg == vp6fhd_pkg::POS_FIRST),
        .ref_dims   (ref_reg),
        .result     (result)
    );

    // Advance the frame state; clear it and load the result on the last byte
    always_comb
    begin
        pos_next       = pos_reg;
        frame_next     = frame_reg;
        ref_next       = ref_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        if (accept)
        begin
            if (s_axis_tlast)
            begin
                pos_next       = '0;
                frame_next     = '0;
                out_next       = result;
                out_valid_next = 1'b1;
                if (result.status == vp6fhd_pkg::ST_OK)
                begin
                    ref_next.valid  = 1'b1;
                    ref_next.width  = result.width;
                    ref_next.height = result.height;
                end
            end
            else
            begin
                frame_next = frame_upd;
                if (pos_reg != vp6fhd_pkg::POS_MAX)
                begin
                    pos_next = pos_reg + 4'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            frame_reg     <= '0;
            ref_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            frame_reg     <= frame_next;
            ref_reg       <= ref_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload: hold until taken
    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.key_frame;
    assign m_axis_tdata  = {6'd0, out_reg.status, out_reg.height, out_reg.width};

endmodule

### hdl/vp6fhd_checker.sv
// Port-level checker for the VP6 frame header dimension unit, with its bind.
`timescale 1ns / 1ps

module vp6fhd_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        s_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic        m_axis_tuser
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // Error results carry zero dimensions
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[25:24] != vp6fhd_pkg::ST_OK
            |-> m_axis_tdata[23:0] == 24'd0)
        else $error("error result with nonzero dimensions");

    // A good key frame has nonzero dimensions
    a_key_ok_dims: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser && m_axis_tdata[25:24] == vp6fhd_pkg::ST_OK
            |-> m_axis_tdata[11:0] != 12'd0 && m_axis_tdata[23:12] != 12'd0)
        else $error("good key frame with zero dimension");

    // A new result only follows an accepted last byte
    a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready && s_axis_tlast))
        else $error("result without a last byte");

    // Never stall input with an empty output register
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled while output empty");

endmodule

bind vp6_frame_header_dims_unit vp6fhd_checker u_vp6fhd_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

### tb/testbench.sv
// Self-checking testbench for the VP6 frame header dimension unit.
`timescale 1ns / 1ps

module testbench;

    typedef logic [7:0] byte_q_t[$];

    // Track the header parse of the frame in flight, predict the report for
    // each frame and check the results that the unit delivers in order.
    class dims_scoreboard;
        vp6fhd_pkg::frame_state_t frame;
        logic [3:0]               pos;
        vp6fhd_pkg::ref_dims_t    stored;
        vp6fhd_pkg::result_t      expected_q[$];
        int                       errors;

        function new();
            frame  = '0;
            pos    = vp6fhd_pkg::POS_FIRST;
            stored = '0;
            errors = 0;
        endfunction

        function void flag(string msg);
            errors++;
            if (errors <= 10)
                $display("[%0t] mismatch: %s", $time, msg);
        endfunction

        // Scale a size code by 16 and trim the adjust nibble; zero or
        // underflow is an error, never a wrapped value.
        function bit scale_dim(logic [7:0] code, logic [3:0] nib,
                               output logic [vp6fhd_pkg::DIM_W-1:0] dim);
            logic [vp6fhd_pkg::DIM_W-1:0] full;
            full = {code, 4'b0000};
            if (code == 8'd0 || nib > full)
            begin
                dim = '0;
                return 1'b0;
            end
            dim = full - nib;
            return dim != '0;
        endfunction

        // Note one accepted byte request; on the last byte queue the report.
        function void note_request(logic [7:0] data, logic last, logic [7:0] adj);
            logic [3:0]                   p;
            logic [3:0]                   hgt_pos;
            logic [vp6fhd_pkg::DIM_W-1:0] w;
            logic [vp6fhd_pkg::DIM_W-1:0] h;
            logic                         ok_w;
            logic                         ok_h;
            vp6fhd_pkg::result_t          res;

            p = pos;
            if (p == vp6fhd_pkg::POS_FIRST)
            begin
                frame.inter       = data[7];
                frame.marker      = data[0];
                frame.held_adjust = adj;
            end
            else if (p == vp6fhd_pkg::POS_VERSION)
                frame.offset = frame.marker && (data[2:1] == 2'b00);

            hgt_pos = frame.offset ? vp6fhd_pkg::POS_HGT_OFS : vp6fhd_pkg::POS_HGT;
            if (p >= vp6fhd_pkg::POS_DIMS && p == hgt_pos)
                frame.height_code = data;
            if (p >= vp6fhd_pkg::POS_DIMS && p == hgt_pos + 4'd1)
            begin
                frame.width_code = data;
                frame.complete   = 1'b1;
            end
            if (pos != vp6fhd_pkg::POS_MAX)
                pos = pos + 4'd1;

            if (!last)
                return;

            res = '0;
            res.key_frame = !frame.inter;
            res.status = vp6fhd_pkg::ST_OK;
            if (p == vp6fhd_pkg::POS_FIRST)
                res.status = vp6fhd_pkg::ST_SHORT;
            else if (frame.inter)
            begin
                if (stored.valid)
                begin
                    res.width  = stored.width;
                    res.height = stored.height;
                end
                else
                    res.status = vp6fhd_pkg::ST_NO_REF;
            end
            else if (!frame.complete)
                res.status = vp6fhd_pkg::ST_SHORT;
            else
            begin
                ok_w = scale_dim(frame.width_code, frame.held_adjust[7:4], w);
                ok_h = scale_dim(frame.height_code, frame.held_adjust[3:0], h);
                res.width  = w;
                res.height = h;
                if (!ok_w || !ok_h)
                    res.status = vp6fhd_pkg::ST_BAD_DIM;
            end

            if (res.status != vp6fhd_pkg::ST_OK)
            begin
                res.width  = '0;
                res.height = '0;
            end
            else
            begin
                stored.valid  = 1'b1;
                stored.width  = res.width;
                stored.height = res.height;
            end
            expected_q.push_back(res);
            frame = '0;
            pos   = vp6fhd_pkg::POS_FIRST;
        endfunction

        // Compare one delivered report with the oldest prediction.
        function void check_result(logic key, logic [vp6fhd_pkg::DIM_W-1:0] w,
                                   logic [vp6fhd_pkg::DIM_W-1:0] h, logic [1:0] st);
            vp6fhd_pkg::result_t exp_res;
            if (expected_q.size() == 0)
            begin
                flag($sformatf("unexpected result key=%0d w=%0d h=%0d st=%0d",
                               key, w, h, st));
                return;
            end
            exp_res = expected_q.pop_front();
            if (key !== exp_res.key_frame)
                flag($sformatf("key_frame exp %0d got %0d", exp_res.key_frame, key));
            if (w !== exp_res.width)
                flag($sformatf("width exp %0d got %0d", exp_res.width, w));
            if (h !== exp_res.height)
                flag($sformatf("height exp %0d got %0d", exp_res.height, h));
            if (st !== exp_res.status)
                flag($sformatf("status exp %0d got %0d", exp_res.status, st));
        endfunction
    endclass

    localparam int CYCLE_LIMIT = 300000;
    localparam int RANDOM_BYTES = 400;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tuser;

    dims_scoreboard sb = new();
    bit             steady = 1'b0;  // suppress idling on both sides
    int             cycles = 0;
    int             sent = 0;

    vp6_frame_header_dims_unit u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Stall the result side at random, except during the steady stretch.
    always @(posedge clk)
        m_axis_tready <= steady || ($urandom_range(99) >= 37);

    // Observe both handshakes on the same edge: note the request first so a
    // report can never overtake the byte that caused it.
    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
            sb.note_request(s_axis_tdata[7:0], s_axis_tlast, s_axis_tdata[15:8]);
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tuser, m_axis_tdata[11:0], m_axis_tdata[23:12],
                            m_axis_tdata[25:24]);
    end

    // Abort a hung run.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("testbench failed");
            $finish;
        end
    end

    // Offer one byte request, idling first at random; hold until accepted.
    task automatic send_byte(input logic [7:0] data, input logic last,
                             input logic [7:0] adj);
        while (!steady && $urandom_range(99) < 37)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {adj, data};
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sent++;
    endtask

    // Stream a whole frame; the adjustment only matters on the first byte,
    // so randomize it elsewhere.
    task automatic send_frame(input byte_q_t bytes, input logic [7:0] adj);
        for (int i = 0; i < bytes.size(); i++)
            send_byte(bytes[i], i == bytes.size() - 1,
                      (i == 0) ? adj : 8'($urandom_range(255)));
    endtask

    function automatic logic [7:0] rand_code();
        case ($urandom_range(9))
            0: return 8'd0;
            1: return 8'd1;
            2: return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // Build a key frame with a random header layout and random size codes.
    function automatic byte_q_t make_key_frame();
        byte_q_t    q;
        logic [7:0] b0;
        logic [7:0] b1;
        logic       with_offset;
        b0 = 8'($urandom_range(255));
        b1 = 8'($urandom_range(255));
        b0[7] = 1'b0;
        with_offset = 1'($urandom_range(1));
        if (with_offset)
        begin
            b0[0] = 1'b1;
            b1[2:1] = 2'b00;
        end
        else if (b0[0])
            b1[2:1] = 2'($urandom_range(3, 1));
        q.push_back(b0);
        q.push_back(b1);
        repeat (with_offset ? 4 : 2)
            q.push_back(8'($urandom_range(255)));
        q.push_back(rand_code());
        q.push_back(rand_code());
        repeat ($urandom_range(3))
            q.push_back(8'($urandom_range(255)));
        // Cut some frames short to hit the truncated header path.
        if ($urandom_range(9) == 0)
            q = q[0:$urandom_range(q.size() - 2)];
        return q;
    endfunction

    function automatic byte_q_t make_inter_frame();
        byte_q_t q;
        q.push_back(8'($urandom_range(255)) | 8'h80);
        repeat ($urandom_range(5))
            q.push_back(8'($urandom_range(255)));
        return q;
    endfunction

    function automatic byte_q_t make_noise_frame();
        byte_q_t q;
        repeat ($urandom_range(18, 1))
            q.push_back(8'($urandom_range(255)));
        return q;
    endfunction

    initial
    begin
        byte_q_t frm;
        int      pick;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed frames: no reference yet, one-byte frames, truncation,
        // extreme codes and adjustment, offset layouts, zero codes, reuse of
        // the reference by inter frames and an over-long frame.
        send_frame('{8'h80, 8'h00}, 8'h00);
        send_frame('{8'h00}, 8'hFF);
        send_frame('{8'hFF}, 8'h00);
        send_frame('{8'h00, 8'h00, 8'h00, 8'h00, 8'hFF}, 8'h00);
        send_frame('{8'h7E, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF}, 8'hFF);
        send_frame('{8'h81, 8'h00, 8'h00}, 8'h00);
        send_frame('{8'h01, 8'h00, 8'hAA, 8'h55, 8'h00, 8'h00, 8'h01, 8'h01}, 8'hFF);
        send_frame('{8'h01, 8'h06, 8'h00, 8'h00, 8'h10, 8'h20}, 8'h00);
        send_frame('{8'h00, 8'h00, 8'h00, 8'h00, 8'h10, 8'h00}, 8'h00);
        send_frame('{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h10}, 8'h00);
        send_frame('{8'h80, 8'h00}, 8'h00);
        send_frame('{8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h20}, 8'h00);
        send_frame('{8'h00, 8'h02, 8'h00, 8'h00, 8'h30, 8'h40, 8'h11, 8'h22,
                     8'h33, 8'h44, 8'h55, 8'h66, 8'h77, 8'h88, 8'h99, 8'hAA,
                     8'hBB, 8'hCC, 8'hDD, 8'hEE}, 8'h5A);

        // Random frames, mostly well-formed, with a stretch of full rate.
        while (sent < RANDOM_BYTES)
        begin
            steady = (sent >= 150 && sent < 230);
            pick = $urandom_range(99);
            if (pick < 55)
                frm = make_key_frame();
            else if (pick < 80)
                frm = make_inter_frame();
            else
                frm = make_noise_frame();
            send_frame(frm, 8'($urandom_range(255)));
        end
        steady = 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tlast  <= 1'b0;

        // Drain outstanding reports, then give stray results time to show.
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (sb.errors == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

### filelist.f
hdl/vp6fhd_pkg.sv
hdl/vp6fhd_result.sv
hdl/vp6_frame_header_dims_unit.sv
hdl/vp6fhd_checker.sv
tb/testbench.sv
